### rtl/core/rbt_pkg.sv
// rbt_pkg: shared types and constants of the binary thinning unit
// no dependencies; imported by rbt_bank and rosenfeld_binary_thinning_unit
package rbt_pkg;

	localparam int MAX_ROWS = 256;
	localparam int MAX_COLS = 256;
	localparam int ADDR_W   = 16;
	localparam int DIM_W    = 9;
	localparam int IDX_W    = 8;
	localparam int CNT_W    = 16;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DIM_W-1:0]  dim_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [1:0] REG_NUM_COLS = 2'd1;

	// sub-pass directions
	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_SOUTH = 2'd1;
	localparam logic [1:0] DIR_EAST  = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP
	} state_t;

endpackage

### rtl/core/rbt_bank.sv
// rbt_bank: one pixel bank, one write port and one registered read port
// depends on rbt_pkg
module rbt_bank (
	input  logic         clk,
	input  logic         we,
	input  rbt_pkg::addr_t waddr,
	input  logic         wdata,
	input  rbt_pkg::addr_t raddr,
	output logic         rdata
);
	import rbt_pkg::*;

	logic mem [0:(1<<ADDR_W)-1];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/rosenfeld_binary_thinning_unit.sv
// rosenfeld_binary_thinning_unit: top level of the 8-connected thinning unit
// depends on rbt_pkg and rbt_bank
//
// channel  direction  handshake           payload
// cfg      in         cfg_valid/cfg_ready cfg_index, cfg_data
// in       in         in_valid/in_stall   opcode, row_index, col_index, pixel_in
// out      out        out_valid/out_stall pixel_out, round_count
//
// write and unused ops are answered straight from idle; a read goes through ST_READ
// for the registered bank read. a start sweeps the whole image once per sub-pass,
// with nine neighbor reads through the single bank read port plus a write per pixel;
// the two banks swap roles after each sub-pass.
// reset clears control state only; pixel banks hold garbage until written.
// one op is in flight at a time; a stalled result holds the next op off.
module rosenfeld_binary_thinning_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  row_index,
	input  logic [7:0]  col_index,
	input  logic        pixel_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pixel_out,
	output logic [15:0] round_count
);
	import rbt_pkg::*;

	state_t st_q, st_d;
	dim_t   rows_cfg_q, cols_cfg_q, rows_eff, cols_eff;
	logic   bank_q, rd_inside_q, chg_q;
	logic [CNT_W-1:0] rounds_q, rnd_q, rnd_inc;
	logic [1:0] dir_q;
	logic [3:0] k_q;
	logic [IDX_W-1:0] r_q, c_q;
	addr_t  p_q, op_addr, raddr, swp_raddr, waddr0, waddr1;
	logic   we0, we1, wd0, wd1, rd0, rd1, rd_cur;
	logic   in_fire, out_fire, op_inside, empty_img;
	logic   out_valid_q, pix_out_q;
	logic [CNT_W-1:0] round_out_q;
	logic [8:0] win;
	logic [7:0] win_q;
	logic   dir_nbr, interior, sum_gt1, keep, del, new_pix, last_pix, pix_end;
	logic [3:0] nsum;
	op_t    op;

	assign op = op_t'(opcode);

	// effective dimensions, saturated to the bank size
	assign rows_eff = (rows_cfg_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_cfg_q;
	assign cols_eff = (cols_cfg_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_cfg_q;
	assign empty_img = (rows_eff == '0) || (cols_eff == '0);

	// handshakes
	assign cfg_ready = 1'b1;
	assign out_fire  = out_valid_q && !out_stall;
	assign in_stall  = (st_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign pixel_out   = pix_out_q;
	assign round_count = round_out_q;

	// op address and range check
	assign op_addr   = ADDR_W'(row_index) * ADDR_W'(cols_eff) + ADDR_W'(col_index);
	assign op_inside = ({1'b0, row_index} < rows_eff) && ({1'b0, col_index} < cols_eff);

	// neighbor address for read step k of the sweep
	always_comb begin
		swp_raddr = p_q;
		unique case (k_q)
			4'd0:    swp_raddr = p_q - ADDR_W'(cols_eff) - ADDR_W'(1);
			4'd1:    swp_raddr = p_q - ADDR_W'(cols_eff);
			4'd2:    swp_raddr = p_q - ADDR_W'(cols_eff) + ADDR_W'(1);
			4'd3:    swp_raddr = p_q - ADDR_W'(1);
			4'd5:    swp_raddr = p_q + ADDR_W'(1);
			4'd6:    swp_raddr = p_q + ADDR_W'(cols_eff) - ADDR_W'(1);
			4'd7:    swp_raddr = p_q + ADDR_W'(cols_eff);
			4'd8:    swp_raddr = p_q + ADDR_W'(cols_eff) + ADDR_W'(1);
			default: swp_raddr = p_q;
		endcase
	end
	assign raddr = (st_q == ST_SWEEP) ? swp_raddr : op_addr;

	// bank ports: ops hit the current bank, sweep writes the other one
	assign pix_end = (st_q == ST_SWEEP) && (k_q == 4'd9);
	assign we0    = (in_fire && op == OP_WRITE && op_inside && !bank_q) || (pix_end && bank_q);
	assign we1    = (in_fire && op == OP_WRITE && op_inside && bank_q) || (pix_end && !bank_q);
	assign waddr0 = (st_q == ST_SWEEP) ? p_q : op_addr;
	assign waddr1 = waddr0;
	assign wd0    = (st_q == ST_SWEEP) ? new_pix : pixel_in;
	assign wd1    = wd0;

	rbt_bank u_bank0 (.clk(clk), .we(we0), .waddr(waddr0), .wdata(wd0), .raddr(raddr),
		.rdata(rd0));
	rbt_bank u_bank1 (.clk(clk), .we(we1), .waddr(waddr1), .wdata(wd1), .raddr(raddr),
		.rdata(rd1));
	assign rd_cur = bank_q ? rd1 : rd0;

	// neighborhood: bit0 n3, 1 n2, 2 n1, 3 n4, 4 center, 5 n8, 6 n5, 7 n6, 8 n7
	assign win = {rd_cur, win_q};

	// neighborhood capture; step 8 wraps to window bit 7 through the 3-bit index
	always_ff @(posedge clk) begin
		if (st_q == ST_SWEEP && k_q != 4'd0 && k_q != 4'd9) begin
			win_q[k_q[2:0] - 3'd1] <= rd_cur;
		end
	end

	// deletion decision
	always_comb begin
		unique case (dir_q)
			DIR_NORTH: dir_nbr = win[1];
			DIR_SOUTH: dir_nbr = win[7];
			DIR_EAST:  dir_nbr = win[5];
			default:   dir_nbr = win[3];
		endcase
		nsum = 4'(win[0]) + 4'(win[1]) + 4'(win[2]) + 4'(win[3])
			+ 4'(win[5]) + 4'(win[6]) + 4'(win[7]) + 4'(win[8]);
		sum_gt1 = nsum > 4'd1;
		keep = (win[1] && !win[3] && !win[5] && (win[6] || win[7] || win[8]))
			|| (win[7] && !win[3] && !win[5] && (win[2] || win[1] || win[0]))
			|| (win[5] && !win[1] && !win[7] && (win[0] || win[3] || win[6]))
			|| (win[3] && !win[1] && !win[7] && (win[8] || win[5] || win[2]))
			|| (win[6] && !win[3] && !win[7])
			|| (win[8] && !win[7] && !win[5])
			|| (win[2] && !win[5] && !win[1])
			|| (win[0] && !win[1] && !win[3]);
		interior = (r_q != '0) && (c_q != '0)
			&& (({1'b0, r_q} + DIM_W'(1)) < rows_eff)
			&& (({1'b0, c_q} + DIM_W'(1)) < cols_eff);
		del = interior && win[4] && !dir_nbr && sum_gt1 && !keep;
		new_pix = win[4] && !del;
		last_pix = ({1'b0, r_q} == rows_eff - DIM_W'(1))
			&& ({1'b0, c_q} == cols_eff - DIM_W'(1));
		rnd_inc = (rnd_q == '1) ? rnd_q : rnd_q + CNT_W'(1);
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_fire && op == OP_READ) st_d = ST_READ;
				else if (in_fire && op == OP_START && !empty_img) st_d = ST_SWEEP;
			end
			ST_READ: st_d = ST_IDLE;
			ST_SWEEP: begin
				if (pix_end && last_pix && dir_q == DIR_WEST && !(chg_q || del)) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= DIM_W'(256);
			cols_cfg_q <= DIM_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_NUM_ROWS) rows_cfg_q <= cfg_data;
			if (cfg_index == REG_NUM_COLS) cols_cfg_q <= cfg_data;
		end
	end

	// sweep control and round counting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0; dir_q <= DIR_NORTH; chg_q <= 1'b0; k_q <= '0;
			p_q <= '0; r_q <= '0; c_q <= '0; rnd_q <= '0; rounds_q <= '0;
			rd_inside_q <= 1'b0;
		end else if (st_q == ST_IDLE) begin
			if (in_fire && op == OP_START) begin
				dir_q <= DIR_NORTH; chg_q <= 1'b0; k_q <= '0;
				p_q <= '0; r_q <= '0; c_q <= '0; rnd_q <= '0;
				if (empty_img) rounds_q <= CNT_W'(1);
			end
			if (in_fire) rd_inside_q <= op_inside;
		end else if (st_q == ST_SWEEP) begin
			if (k_q != 4'd9) begin
				k_q <= k_q + 4'd1;
			end else begin
				k_q <= '0;
				if (!last_pix) begin
					if (del) chg_q <= 1'b1;
					p_q <= p_q + ADDR_W'(1);
					if ({1'b0, c_q} == cols_eff - DIM_W'(1)) begin
						c_q <= '0; r_q <= r_q + IDX_W'(1);
					end else begin
						c_q <= c_q + IDX_W'(1);
					end
				end else begin
					// end of sub-pass: swap banks, next direction
					p_q <= '0; r_q <= '0; c_q <= '0;
					bank_q <= !bank_q;
					dir_q <= dir_q + 2'd1;
					if (dir_q == DIR_WEST) begin
						rnd_q <= rnd_inc;
						chg_q <= 1'b0;
						if (!(chg_q || del)) rounds_q <= rnd_inc;
					end else if (del) begin
						chg_q <= 1'b1;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && op != OP_READ && !(op == OP_START && !empty_img)) begin
			out_valid_q <= 1'b1;
		end else if (st_q == ST_READ) begin
			out_valid_q <= 1'b1;
		end else if (st_q == ST_SWEEP && st_d == ST_IDLE) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire && op != OP_READ && !(op == OP_START && !empty_img)) begin
			pix_out_q <= 1'b0;
			round_out_q <= (op == OP_START) ? CNT_W'(1) : rounds_q;
		end else if (st_q == ST_READ) begin
			pix_out_q <= rd_inside_q && rd_cur;
			round_out_q <= rounds_q;
		end else if (st_q == ST_SWEEP && st_d == ST_IDLE) begin
			pix_out_q <= 1'b0;
			round_out_q <= rnd_inc;
		end
	end

endmodule
